>>> rtl/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Types, constants and register codes shared by the reflow profile sequencer.
// ----------------------------------------------------------------------------
package rps_pkg;

   localparam int TICK_RATE_DEF  = 1000;
   localparam int MAX_PHASES_DEF = 5;

   localparam int SLOTS      = 5;
   localparam int TEMP_W     = 10;
   localparam int DUR_W      = 12;
   localparam int DIV_W      = 32;
   localparam int TPD_W      = 23;
   localparam int CSR_AW     = 6;
   localparam int CSR_DW     = 64;
   localparam int REQ_DW     = 24;
   localparam int RSP_DW     = 40;

   localparam logic [TEMP_W-1:0] HOT_LIMIT   = 10'd55;
   localparam logic [TPD_W-1:0]  TPD_MAX     = 23'h7FFFFF;
   localparam logic [15:0]       LATE_MARGIN = 16'd2;

   typedef enum logic [2:0] {
      REG_PHASE_COUNT    = 3'd0,
      REG_PREHEAT_TEMP   = 3'd1,
      REG_PREHEAT_SPEED  = 3'd2,
      REG_COOLDOWN_SPEED = 3'd3,
      REG_GOALS          = 3'd4,
      REG_DURATIONS      = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_RUNNING   = 3'd0,
      ST_TOO_HOT   = 3'd1,
      ST_USER_EXIT = 3'd2,
      ST_FINISHED  = 3'd3,
      ST_RUNAWAY   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      LED_WARMING = 2'd0,
      LED_HOT     = 2'd1,
      LED_COOLING = 2'd2,
      LED_RESTING = 2'd3
   } led_type;

   typedef struct packed {
      logic [2:0]              phase_count;
      logic [TEMP_W-1:0]       preheat_temp;
      logic [3:0]              preheat_speed;
      logic [3:0]              cooldown_speed;
      logic [SLOTS*TEMP_W-1:0] phase_goal_temps;
      logic [SLOTS*DUR_W-1:0]  phase_durations;
   } cfg_type;

   typedef struct packed {
      logic              thermal_runaway;
      logic              exit_request;
      logic [TEMP_W-1:0] tip_temp_c;
      logic [TEMP_W-1:0] tip_temp;
   } req_type;

   typedef struct packed {
      logic              behind_schedule;
      logic [15:0]       elapsed_seconds;
      logic              buzzer_on;
      led_type           led_mode;
      status_type        status;
      logic [2:0]        phase;
      logic [TEMP_W-1:0] target_temp;
   } rsp_type;

   function automatic rsp_type stop_rsp(status_type st, logic [2:0] ph);
      rsp_type r;
      r.behind_schedule = 1'b0;
      r.elapsed_seconds = 16'd0;
      r.buzzer_on       = 1'b0;
      r.led_mode        = LED_RESTING;
      r.status          = st;
      r.phase           = ph;
      r.target_temp     = '0;
      return r;
   endfunction

endpackage

>>> rtl/rps_div.sv
// ----------------------------------------------------------------------------
// rps_div
// Restoring divider, one quotient bit per cycle, done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module rps_div
   import rps_pkg::*;
#(
   parameter int W = DIV_W
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic         done,
   output logic [W-1:0] quot
);

   localparam int CW = $clog2(W);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;
   logic [W:0]    diff;

   always_comb begin
      trial   = {rem_ff, q_ff[W-1]};
      diff    = trial - {1'b0, den};
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (go) begin
         rem_in  = '0;
         q_in    = num;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den}) begin
            rem_in = diff[W-1:0];
            q_in   = {q_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            q_in   = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

   a_go_idle: assert property (@(posedge clock) disable iff (reset) busy_ff |-> !go)
      else $error("divider started while busy");
   a_latency: assert property (@(posedge clock) disable iff (reset) go |-> ##(W+1) done)
      else $error("divider latency wrong");
   a_done_free: assert property (@(posedge clock) disable iff (reset) done |-> !busy_ff)
      else $error("divider busy at done");

endmodule

>>> rtl/rps_csr.sv
// ----------------------------------------------------------------------------
// rps_csr
// Configuration register file behind a bus slave port, 64-bit registers.
// ----------------------------------------------------------------------------
module rps_csr
   import rps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[CSR_AW-1:3];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PHASE_COUNT:    cfg_in.phase_count      = pwdata[2:0];
            REG_PREHEAT_TEMP:   cfg_in.preheat_temp     = pwdata[TEMP_W-1:0];
            REG_PREHEAT_SPEED:  cfg_in.preheat_speed    = pwdata[3:0];
            REG_COOLDOWN_SPEED: cfg_in.cooldown_speed   = pwdata[3:0];
            REG_GOALS:          cfg_in.phase_goal_temps = pwdata[SLOTS*TEMP_W-1:0];
            REG_DURATIONS:      cfg_in.phase_durations  = pwdata[SLOTS*DUR_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PHASE_COUNT:    prdata = CSR_DW'(cfg_ff.phase_count);
         REG_PREHEAT_TEMP:   prdata = CSR_DW'(cfg_ff.preheat_temp);
         REG_PREHEAT_SPEED:  prdata = CSR_DW'(cfg_ff.preheat_speed);
         REG_COOLDOWN_SPEED: prdata = CSR_DW'(cfg_ff.cooldown_speed);
         REG_GOALS:          prdata = CSR_DW'(cfg_ff.phase_goal_temps);
         REG_DURATIONS:      prdata = CSR_DW'(cfg_ff.phase_durations);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_count      <= 3'd1;
         cfg_ff.preheat_temp     <= 10'd150;
         cfg_ff.preheat_speed    <= 4'd1;
         cfg_ff.cooldown_speed   <= 4'd2;
         cfg_ff.phase_goal_temps <= '0;
         cfg_ff.phase_durations  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/reflow_profile_sequencer.sv
// ----------------------------------------------------------------------------
// reflow_profile_sequencer
// Preheat, profile phases and cooldown setpoint sequencer for a reflow tip.
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one scheduler tick per item with the tip readings
//   and the exit and runaway flags; rsp channel returns one item per tick
//   with the ramped setpoint, phase, status, led mode, buzzer, elapsed
//   seconds and the late flag. csr port holds the profile registers at
//   byte address 8*i; write them only while no item is in flight.
//   one item is worked at a time. a stopped profile takes no division;
//   a running one divides for elapsed seconds, for the ramp offset while
//   it ramps and for the ramp rate when a phase is entered. the result is
//   offered in the same cycle that the next item can be taken. all of these
//   divisions share the one bit-serial divider, used in turn.
//   results wait in an output register; the next item is taken while a
//   result is still held, and the block stalls only when a new result is
//   ready and the old one has not been taken.
//   reset returns control and csr registers to defaults, the profile to the
//   not-started state; the first tick then latches the start temperature.
// ----------------------------------------------------------------------------
module reflow_profile_sequencer
   import rps_pkg::*;
#(
   parameter int TICK_RATE  = TICK_RATE_DEF,
   parameter int MAX_PHASES = MAX_PHASES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // tip_temp[9:0], tip_temp_c[19:10], exit_request[20], thermal_runaway[21]
   input  logic [REQ_DW-1:0] req_tdata,
   input  logic              req_tvalid,
   output logic              req_tready,
   // target_temp[9:0], phase[12:10], status[15:13], led_mode[17:16],
   // buzzer_on[18], elapsed_seconds[34:19], behind_schedule[35]
   output logic [RSP_DW-1:0] rsp_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam logic [11:0]      BEEP_TICKS = 12'(TICK_RATE / 3);
   localparam logic [DIV_W-1:0] TICK_DIV   = DIV_W'(TICK_RATE);

   typedef enum logic [10:0] {
      S_IDLE       = 11'b00000000001,
      S_CHECK      = 11'b00000000010,
      S_WAIT_SPEED = 11'b00000000100,
      S_WAIT_EL    = 11'b00000001000,
      S_ADV        = 11'b00000010000,
      S_SPAN       = 11'b00000100000,
      S_WAIT_SPAN  = 11'b00001000000,
      S_POST       = 11'b00010000000,
      S_WAIT_RAMP  = 11'b00100000000,
      S_FIN        = 11'b01000000000,
      S_DONE       = 11'b10000000000
   } state_type;

   cfg_type cfg;
   req_type req_ff;
   rsp_type res_ff, res_in;
   rsp_type rsp_ff;

   state_type          state_ff, state_in;
   logic [2:0]         idx_ff, idx_in;
   logic [31:0]        ticks_ff, ticks_in;
   logic [DUR_W-1:0]   dur_ff, dur_in;
   logic [TEMP_W-1:0]  goal_ff, goal_in;
   logic [TEMP_W-1:0]  start_ff, start_in;
   logic [TPD_W-1:0]   tpd_ff, tpd_in;
   logic               started_ff, started_in;
   logic [11:0]        beep_left_ff, beep_left_in;
   logic               beep_started_ff, beep_started_in;
   status_type         final_ff, final_in;
   logic [15:0]        el_ff, el_in;
   logic [TEMP_W-1:0]  target_ff, target_in;
   logic               div_go_ff, div_go_in;
   logic [DIV_W-1:0]   div_num_ff, div_num_in;
   logic [DIV_W-1:0]   div_den_ff, div_den_in;
   logic               rsp_valid_ff;

   logic               div_done;
   logic [DIV_W-1:0]   div_q;
   logic [2:0]         count;
   logic [2:0]         shown;
   logic               cooling;
   logic [TEMP_W-1:0]  span;
   logic [TEMP_W-1:0]  goal_slot [SLOTS];
   logic [DUR_W-1:0]   dur_slot [SLOTS];
   logic               out_free;
   logic [3:0]         speed_pre;
   logic [3:0]         speed_cool;

   rps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   rps_div #(.W(DIV_W)) u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         goal_slot[i] = cfg.phase_goal_temps[i*TEMP_W +: TEMP_W];
         dur_slot[i]  = cfg.phase_durations[i*DUR_W +: DUR_W];
      end
   end

   // phase count is read live and clamped
   always_comb begin
      if (cfg.phase_count == 3'd0) begin
         count = 3'd1;
      end else if (cfg.phase_count > 3'(MAX_PHASES)) begin
         count = 3'(MAX_PHASES);
      end else begin
         count = cfg.phase_count;
      end
   end

   assign shown      = (idx_ff > count) ? count + 3'd1 : idx_ff;
   assign cooling    = idx_ff > count;
   assign span       = (start_ff < goal_ff) ? goal_ff - start_ff : start_ff - goal_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign speed_pre  = (cfg.preheat_speed == 4'd0) ? 4'd1 : cfg.preheat_speed;
   assign speed_cool = (cfg.cooldown_speed == 4'd0) ? 4'd1 : cfg.cooldown_speed;
   assign req_tready = state_ff == S_IDLE;

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      ticks_in        = ticks_ff;
      dur_in          = dur_ff;
      goal_in         = goal_ff;
      start_in        = start_ff;
      tpd_in          = tpd_ff;
      started_in      = started_ff;
      beep_left_in    = beep_left_ff;
      beep_started_in = beep_started_ff;
      final_in        = final_ff;
      el_in           = el_ff;
      target_in       = target_ff;
      res_in          = res_ff;
      div_go_in       = 1'b0;
      div_num_in      = div_num_ff;
      div_den_in      = div_den_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            if (final_ff != ST_RUNNING) begin
               res_in   = stop_rsp(final_ff, shown);
               state_in = S_DONE;
            end else if (req_ff.exit_request) begin
               final_in = ST_USER_EXIT;
               res_in   = stop_rsp(ST_USER_EXIT, shown);
               state_in = S_DONE;
            end else if (!started_ff) begin
               started_in = 1'b1;
               idx_in     = 3'd0;
               goal_in    = cfg.preheat_temp;
               dur_in     = '0;
               ticks_in   = '0;
               start_in   = req_ff.tip_temp;
               el_in      = '0;
               if (req_ff.tip_temp >= HOT_LIMIT) begin
                  final_in = ST_TOO_HOT;
                  res_in   = stop_rsp(ST_TOO_HOT, 3'd0);
                  state_in = S_DONE;
               end else begin
                  div_go_in  = 1'b1;
                  div_num_in = TICK_DIV;
                  div_den_in = DIV_W'(speed_pre);
                  state_in   = S_WAIT_SPEED;
               end
            end else begin
               div_go_in  = 1'b1;
               div_num_in = ticks_ff;
               div_den_in = TICK_DIV;
               state_in   = S_WAIT_EL;
            end
         end

         S_WAIT_SPEED: begin
            if (div_done) begin
               tpd_in   = (div_q == '0) ? TPD_W'(1) : div_q[TPD_W-1:0];
               // preheat goes on to the advance check, cooldown is already entered
               state_in = (idx_ff == 3'd0) ? S_ADV : S_POST;
            end
         end

         S_WAIT_EL: begin
            if (div_done) begin
               el_in    = (div_q > DIV_W'(16'hFFFF)) ? 16'hFFFF : div_q[15:0];
               state_in = S_ADV;
            end
         end

         S_ADV: begin
            if (idx_ff <= count && el_ff >= 16'(dur_ff) && req_ff.tip_temp == goal_ff) begin
               idx_in   = idx_ff + 3'd1;
               start_in = goal_ff;
               ticks_in = '0;
               el_in    = '0;
               if (idx_ff + 3'd1 > count) begin
                  dur_in     = '0;
                  goal_in    = '0;
                  div_go_in  = 1'b1;
                  div_num_in = TICK_DIV;
                  div_den_in = DIV_W'(speed_cool);
                  state_in   = S_WAIT_SPEED;
               end else begin
                  goal_in  = goal_slot[idx_ff];
                  dur_in   = dur_slot[idx_ff];
                  state_in = S_SPAN;
               end
            end else begin
               state_in = S_POST;
            end
         end

         S_SPAN: begin
            if (span == '0) begin
               tpd_in   = '0;
               state_in = S_POST;
            end else begin
               div_go_in  = 1'b1;
               div_num_in = DIV_W'(dur_ff) * TICK_DIV;
               div_den_in = DIV_W'(span);
               state_in   = S_WAIT_SPAN;
            end
         end

         S_WAIT_SPAN: begin
            if (div_done) begin
               tpd_in   = (div_q > DIV_W'(TPD_MAX)) ? TPD_MAX : div_q[TPD_W-1:0];
               state_in = S_POST;
            end
         end

         S_POST: begin
            if (cooling && req_ff.tip_temp_c < HOT_LIMIT && !beep_started_ff) begin
               beep_started_in = 1'b1;
               beep_left_in    = BEEP_TICKS;
            end
            if (tpd_ff != '0 && start_ff != goal_ff) begin
               div_go_in  = 1'b1;
               div_num_in = ticks_ff;
               div_den_in = DIV_W'(tpd_ff);
               state_in   = S_WAIT_RAMP;
            end else begin
               target_in = goal_ff;
               state_in  = S_FIN;
            end
         end

         S_WAIT_RAMP: begin
            if (div_done) begin
               target_in = goal_ff;
               if (div_q < DIV_W'(span)) begin
                  target_in = (start_ff < goal_ff) ? start_ff + div_q[TEMP_W-1:0]
                                                   : start_ff - div_q[TEMP_W-1:0];
               end
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            if (beep_started_ff && beep_left_ff == '0) begin
               final_in = ST_FINISHED;
               res_in   = stop_rsp(ST_FINISHED, shown);
            end else if (req_ff.thermal_runaway) begin
               final_in = ST_RUNAWAY;
               res_in   = stop_rsp(ST_RUNAWAY, shown);
            end else begin
               res_in.target_temp     = target_ff;
               res_in.phase           = shown;
               res_in.status          = ST_RUNNING;
               res_in.buzzer_on       = beep_started_ff;
               res_in.elapsed_seconds = el_ff;
               if (idx_ff == 3'd0) begin
                  res_in.led_mode = LED_WARMING;
               end else if (cooling) begin
                  res_in.led_mode = (req_ff.tip_temp_c < HOT_LIMIT) ? LED_RESTING
                                                                    : LED_COOLING;
               end else begin
                  res_in.led_mode = LED_HOT;
               end
               res_in.behind_schedule = !cooling && idx_ff != 3'd0 &&
                                        el_ff >= 16'(dur_ff) + LATE_MARGIN;
               if (ticks_ff != '1) begin
                  ticks_in = ticks_ff + 32'd1;
               end
               if (beep_started_ff && beep_left_ff != '0) begin
                  beep_left_in = beep_left_ff - 12'd1;
               end
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         idx_ff          <= '0;
         ticks_ff        <= '0;
         dur_ff          <= '0;
         goal_ff         <= '0;
         start_ff        <= '0;
         tpd_ff          <= '0;
         started_ff      <= 1'b0;
         beep_left_ff    <= '0;
         beep_started_ff <= 1'b0;
         final_ff        <= ST_RUNNING;
         div_go_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         idx_ff          <= idx_in;
         ticks_ff        <= ticks_in;
         dur_ff          <= dur_in;
         goal_ff         <= goal_in;
         start_ff        <= start_in;
         tpd_ff          <= tpd_in;
         started_ff      <= started_in;
         beep_left_ff    <= beep_left_in;
         beep_started_ff <= beep_started_in;
         final_ff        <= final_in;
         div_go_ff       <= div_go_in;
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      el_ff      <= el_in;
      target_ff  <= target_in;
      res_ff     <= res_in;
      div_num_ff <= div_num_in;
      div_den_ff <= div_den_in;
      if (state_ff == S_IDLE && req_tvalid) begin
         req_ff <= req_type'(req_tdata[$bits(req_type)-1:0]);
      end
      if (state_ff == S_DONE && out_free) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DW'(rsp_ff);

endmodule
